### src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int DEF_NUM_BLOCKS = 16384;

   // bitmap word geometry
   localparam int WORD_W    = 32;
   localparam int WORD_BITS = 5;
   // block positions; ranges end below 2^16 for any legal request
   localparam int POS_W     = 16;
   localparam int WIDX_W    = POS_W - WORD_BITS;

   localparam int OPC_W   = 2;
   localparam int START_W = 14;
   localparam int COUNT_W = 15;
   localparam int STAT_W  = 2;
   localparam int MAP_W   = 15;

   localparam logic [OPC_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OPC_W-1:0] OP_FREE    = 2'd1;
   localparam logic [OPC_W-1:0] OP_CHECK   = 2'd2;
   localparam logic [OPC_W-1:0] OP_RESERVE = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FREE = 2'd1;
   localparam logic [STAT_W-1:0] ST_BOUNDS   = 2'd2;

   localparam logic [MAP_W-1:0] MAP_RESET = 15'd16384;

   typedef struct packed {
      logic              load;
      logic              set_status;
      logic [STAT_W-1:0] status_code;
      logic              scan_init;
      logic              scan_step;
      logic              scan_hit;
      logic              range_init;
      logic              range_step;
      logic              emit;
      logic              clear_step;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic zero_cnt;
      logic is_alloc;
      logic too_big;
      logic oob;
      logic hit;
      logic scan_last;
      logic range_last;
   } dp_stat_type;

endpackage

### src/bitmap_block_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top
// First-fit free-space bitmap allocator: allocate, free, check, reserve.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  request   start && !busy          req_opcode, req_start_block, req_block_count
//  response  rsp_strobe (one cycle)  rsp_status, rsp_run_start
//  config    csr_wr_en               csr_wr_data (map length)
//
//  Bitmap is 32-bit words in one RAM; each word visited takes a read state
//  and an evaluate state. Allocate scans words up to the hit, then marks
//  the words of the run. Free/check/reserve visit each word touched.
//  After reset a clear pass over all ceil(NUM_BLOCKS/32) words holds busy high.
//  The response cannot be stalled; one item is in flight at a time.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_top #(
   parameter int NUM_BLOCKS = bba_pkg::DEF_NUM_BLOCKS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [bba_pkg::OPC_W-1:0]    req_opcode,
   input  logic [bba_pkg::START_W-1:0]  req_start_block,
   input  logic [bba_pkg::COUNT_W-1:0]  req_block_count,
   output logic                         rsp_strobe,
   output logic [bba_pkg::STAT_W-1:0]   rsp_status,
   output logic [bba_pkg::START_W-1:0]  rsp_run_start,
   input  logic                         csr_wr_en,
   input  logic [bba_pkg::MAP_W-1:0]    csr_wr_data
);
   import bba_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   bba_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   bba_datapath #(.NUM_BLOCKS(NUM_BLOCKS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_start_block (req_start_block),
      .req_block_count (req_block_count),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_run_start   (rsp_run_start)
   );

`ifndef SYNTHESIS
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status == ST_OK || rsp_status == ST_NOT_FREE ||
                      rsp_status == ST_BOUNDS))
      else $error("bad status code");
   a_run_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |-> (rsp_run_start == '0))
      else $error("run start on failed item");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while busy");
`endif
endmodule

### src/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### src/bba_datapath.sv
// ----------------------------------------------------------------------------
// bba_datapath
// Request registers, bitmap RAM, word scan for free runs and range masking.
// ----------------------------------------------------------------------------
module bba_datapath #(
   parameter int NUM_BLOCKS = bba_pkg::DEF_NUM_BLOCKS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  bba_pkg::dp_cmd_type              cmd,
   output bba_pkg::dp_stat_type             stat,
   input  logic [bba_pkg::OPC_W-1:0]        req_opcode,
   input  logic [bba_pkg::START_W-1:0]      req_start_block,
   input  logic [bba_pkg::COUNT_W-1:0]      req_block_count,
   input  logic                             csr_wr_en,
   input  logic [bba_pkg::MAP_W-1:0]        csr_wr_data,
   output logic                             rsp_strobe,
   output logic [bba_pkg::STAT_W-1:0]       rsp_status,
   output logic [bba_pkg::START_W-1:0]      rsp_run_start
);
   import bba_pkg::*;

   localparam int DEPTH = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [POS_W-1:0] NUM_CAP =
      (NUM_BLOCKS > 32767) ? POS_W'(32767) : POS_W'(NUM_BLOCKS);

   logic [MAP_W-1:0]   map_ff;
   logic [OPC_W-1:0]   op_ff;
   logic [START_W-1:0] first_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [POS_W-1:0]   len_ff, streak_ff, lo_ff, hi_ff, run_ff;
   logic [WIDX_W-1:0]  word_ff;
   logic [STAT_W-1:0]  status_ff;
   logic [AW-1:0]      clr_ff;
   logic               rsp_strobe_ff;
   logic [STAT_W-1:0]  rsp_status_ff;
   logic [START_W-1:0] rsp_run_ff;

   logic [WORD_W-1:0]  rdata, wdata, bits, mask;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [POS_W-1:0]   base, count_x, end_pos, len_in, run_calc, streak_in;
   logic [WORD_W-1:0]  le_ok, win_ok, hit_vec;
   logic [WORD_BITS-1:0] hit_idx;
   logic [WORD_BITS:0]   top_ones;

   assign count_x = POS_W'(count_ff);
   assign end_pos = POS_W'(first_ff) + count_x;
   assign base    = {word_ff, {WORD_BITS{1'b0}}};
   assign len_in  = (POS_W'(map_ff) < NUM_CAP) ? POS_W'(map_ff) : NUM_CAP;

   // per-position run test: a run ending at bit j either lies in this word
   // or continues the streak carried in from lower words
   always_comb begin
      bits     = '0;
      mask     = '0;
      le_ok    = '1;
      win_ok   = '1;
      hit_vec  = '0;
      hit_idx  = '0;
      top_ones = (WORD_BITS+1)'(WORD_W);
      for (int b = 0; b < WORD_W; b++) begin
         bits[b] = rdata[b] && ((base + POS_W'(b)) < len_ff);
         mask[b] = ((base + POS_W'(b)) >= lo_ff) && ((base + POS_W'(b)) <= hi_ff);
      end
      for (int j = 0; j < WORD_W; j++) begin
         for (int b = 0; b < WORD_W; b++) begin
            if (b <= j && !bits[b]) begin
               le_ok[j] = 1'b0;
               if (POS_W'(b) + count_x > POS_W'(j)) begin
                  win_ok[j] = 1'b0;
               end
            end
         end
         hit_vec[j] = (le_ok[j] && (streak_ff + POS_W'(j + 1) >= count_x)) ||
                      ((count_x <= POS_W'(j + 1)) && win_ok[j]);
      end
      for (int j = WORD_W - 1; j >= 0; j--) begin
         if (hit_vec[j]) begin
            hit_idx = WORD_BITS'(j);
         end
      end
      for (int b = 0; b < WORD_W; b++) begin
         if (!bits[b]) begin
            top_ones = (WORD_BITS+1)'(WORD_W - 1 - b);
         end
      end
   end

   assign run_calc  = base + POS_W'(hit_idx) + POS_W'(1) - count_x;
   assign streak_in = (&bits) ? streak_ff + POS_W'(WORD_W) : POS_W'(top_ones);

   assign wdata     = cmd.clear_step ? '1 :
                      (op_ff == OP_FREE) ? (rdata | mask) : (rdata & ~mask);
   assign ram_we    = cmd.clear_step || (cmd.range_step && op_ff != OP_CHECK);
   assign ram_waddr = cmd.clear_step ? clr_ff : AW'(word_ff);

   bba_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (wdata),
      .rd_addr (AW'(word_ff)),
      .rd_data (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff        <= MAP_RESET;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            map_ff <= csr_wr_data;
         end
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + AW'(1);
         end
         rsp_strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_opcode;
         first_ff  <= req_start_block;
         count_ff  <= req_block_count;
         len_ff    <= len_in;
         status_ff <= ST_OK;
         run_ff    <= '0;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status_code;
      end
      if (cmd.scan_init) begin
         word_ff   <= '0;
         streak_ff <= '0;
      end
      if (cmd.scan_step) begin
         word_ff   <= word_ff + WIDX_W'(1);
         streak_ff <= streak_in;
      end
      if (cmd.scan_hit) begin
         run_ff  <= run_calc;
         lo_ff   <= run_calc;
         hi_ff   <= run_calc + count_x - POS_W'(1);
         word_ff <= WIDX_W'(run_calc >> WORD_BITS);
      end
      if (cmd.range_init) begin
         lo_ff   <= POS_W'(first_ff);
         hi_ff   <= end_pos - POS_W'(1);
         word_ff <= WIDX_W'(first_ff >> WORD_BITS);
      end
      if (cmd.range_step) begin
         word_ff <= word_ff + WIDX_W'(1);
         if (op_ff == OP_CHECK && (rdata & mask) != mask) begin
            status_ff <= ST_NOT_FREE;
         end
      end
      if (cmd.emit) begin
         rsp_status_ff <= status_ff;
         rsp_run_ff    <= run_ff[START_W-1:0];
      end
   end

   assign stat.clear_last = (clr_ff == AW'(DEPTH - 1));
   assign stat.zero_cnt   = (count_ff == '0);
   assign stat.is_alloc   = (op_ff == OP_ALLOC);
   assign stat.too_big    = (count_x > len_ff);
   assign stat.oob        = (end_pos > len_ff);
   assign stat.hit        = |hit_vec;
   assign stat.scan_last  = (word_ff == WIDX_W'((len_ff - POS_W'(1)) >> WORD_BITS));
   assign stat.range_last = (word_ff == WIDX_W'(hi_ff >> WORD_BITS));

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_run_start = rsp_run_ff;
endmodule

### src/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: bitmap clear after reset, request decode, run scan, range pass.
// ----------------------------------------------------------------------------
module bba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output bba_pkg::dp_cmd_type  cmd,
   input  bba_pkg::dp_stat_type stat
);
   import bba_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_SCRD   = 3'd3;
   localparam logic [2:0] S_SCEV   = 3'd4;
   localparam logic [2:0] S_RGRD   = 3'd5;
   localparam logic [2:0] S_RGEV   = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.zero_cnt) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_BOUNDS;
               state_in        = S_DONE;
            end else if (stat.is_alloc) begin
               if (stat.too_big) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_NOT_FREE;
                  state_in        = S_DONE;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_SCRD;
               end
            end else if (stat.oob) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_BOUNDS;
               state_in        = S_DONE;
            end else begin
               cmd.range_init = 1'b1;
               state_in       = S_RGRD;
            end
         end
         S_SCRD: begin
            state_in = S_SCEV;
         end
         S_SCEV: begin
            if (stat.hit) begin
               cmd.scan_hit = 1'b1;
               state_in     = S_RGRD;
            end else if (stat.scan_last) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_NOT_FREE;
               state_in        = S_DONE;
            end else begin
               cmd.scan_step = 1'b1;
               state_in      = S_SCRD;
            end
         end
         S_RGRD: begin
            state_in = S_RGEV;
         end
         S_RGEV: begin
            cmd.range_step = 1'b1;
            state_in       = stat.range_last ? S_DONE : S_RGRD;
         end
         S_DONE: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

`ifndef SYNTHESIS
   a_emit_once: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> !cmd.emit)
      else $error("emit repeated");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");
   a_one_write_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_step, cmd.range_step, cmd.scan_step, cmd.scan_hit}))
      else $error("conflicting datapath commands");
`endif
endmodule
